// ===== rtl/tld_pkg.sv =====
// Shared constants, command and status types for the terminal line discipline.
package tld_pkg;

   // Line buffer sizing
   localparam int LINE_CAPACITY = 32;
   localparam int LEN_W         = $clog2(LINE_CAPACITY);

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_CANONICAL_MODE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ECHO_ENABLE    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIGNAL_ENABLE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_FOREGROUND  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ERASE_KEY      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTER_KEY      = 3'd5;

   localparam logic [7:0] ERASE_KEY_RST = 8'h08;
   localparam logic [7:0] ENTER_KEY_RST = 8'h0d;

   // Character codes
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_INTR    = 8'h03;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_UPPER_C = 8'h43;
   localparam logic [7:0] CH_CARET   = 8'h5e;
   localparam logic [7:0] CH_DEL     = 8'h7f;

   // Result destinations
   localparam logic DEST_READER = 1'b0;
   localparam logic DEST_ECHO   = 1'b1;

   // Source of the outgoing byte
   typedef enum logic [2:0] {
      SRC_CARET,
      SRC_C,
      SRC_LF,
      SRC_NUL,
      SRC_CHAR,
      SRC_MEM,
      SRC_ERASE,
      SRC_SPACE
   } out_src_type;

   // Buffer pointer operations
   typedef enum logic [2:0] {
      PTR_HOLD,
      PTR_TOP,
      PTR_ZERO,
      PTR_DEC,
      PTR_INC
   } ptr_op_type;

   // Line length operations
   typedef enum logic [1:0] {
      LEN_HOLD,
      LEN_CLEAR,
      LEN_INC,
      LEN_TO_PTR
   } len_op_type;

   typedef struct packed {
      logic        capture;
      logic        wr_en;
      logic        rd_en;
      logic        scan_chk;
      ptr_op_type  ptr_op;
      len_op_type  len_op;
      logic        out_load;
      out_src_type out_src;
      logic        out_dest;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic canon;
      logic echo;
      logic nofg;
      logic is_intr;
      logic is_erase;
      logic is_enter;
      logic is_store;
      logic len_zero;
      logic scan_more;
      logic wide;
      logic drain_more;
      logic slot_free;
   } status_type;

endpackage

// ===== rtl/tty_line_discipline.sv =====
// Top level of the terminal line discipline: controller plus datapath, one item in work at a time.
// A stored or raw byte passes the decode state, then an emit state loads its first result.
// A new item waits in idle until every result of the last is loaded, which stalls on the result side.
// Erase goes through a read state and a check state per byte scanned back; enter reads each buffered
// byte through the registered read of the line memory before loading it as a result.
// Reset clears control, empties the line and restores register defaults; no clearing pass.
module tty_line_discipline (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_in_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_dest,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic [tld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tld_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tld_pkg::*;

   cmd_type    cmd;
   status_type status;

   tld_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tld_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .req_in_byte  (req_in_byte),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_dest     (rsp_dest),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .rsp_ready    (rsp_ready)
   );

endmodule

// ===== rtl/tld_datapath.sv =====
// Datapath: configuration registers, line memory, scan window and result register.
module tld_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [7:0]                    req_in_byte,
   input  logic                          csr_we,
   input  logic [tld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tld_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  tld_pkg::cmd_type              cmd,
   output tld_pkg::status_type           status,
   output logic                          rsp_valid,
   output logic                          rsp_dest,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last,
   input  logic                          rsp_ready
);
   import tld_pkg::*;

   logic             canon_ff, echo_ff, sig_ff, nofg_ff;
   logic [7:0]       erase_key_ff, enter_key_ff;
   logic [7:0]       c_ff;
   logic [LEN_W-1:0] len_ff, len_in;
   logic [LEN_W-1:0] ptr_ff, ptr_in;
   logic [LEN_W-1:0] len_top;
   logic [LEN_W-1:0] nbytes;
   logic [7:0]       line_mem [LINE_CAPACITY];
   logic [7:0]       rd_ff;
   logic [7:0]       win1_ff, win2_ff;
   logic             wide_ff;
   logic [15:0]      cp;
   logic             valid_ff;
   logic             dest_ff, last_ff;
   logic [7:0]       byte_ff;
   logic [7:0]       out_sel;

   function automatic logic is_cont(input logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic logic cp_is_wide(input logic [15:0] v);
      return (v >= 16'h3000 && v <= 16'h303e) ||
             (v >= 16'h3041 && v <= 16'h3096) ||
             (v >= 16'h3099 && v <= 16'h30ff) ||
             (v >= 16'h3400 && v <= 16'h9fff) ||
             (v >= 16'hff01 && v <= 16'hff60) ||
             (v >= 16'hffe0 && v <= 16'hffe6);
   endfunction

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         canon_ff     <= 1'b1;
         echo_ff      <= 1'b1;
         sig_ff       <= 1'b1;
         nofg_ff      <= 1'b1;
         erase_key_ff <= ERASE_KEY_RST;
         enter_key_ff <= ENTER_KEY_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CANONICAL_MODE: canon_ff     <= csr_wdata[0];
            CSR_ECHO_ENABLE:    echo_ff      <= csr_wdata[0];
            CSR_SIGNAL_ENABLE:  sig_ff       <= csr_wdata[0];
            CSR_NO_FOREGROUND:  nofg_ff      <= csr_wdata[0];
            CSR_ERASE_KEY:      erase_key_ff <= csr_wdata;
            CSR_ENTER_KEY:      enter_key_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Hold the accepted item
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         c_ff <= req_in_byte;
      end
   end

   assign len_top = len_ff - 1'b1;

   // Next pointer and line length
   always_comb begin
      case (cmd.ptr_op)
         PTR_TOP:  ptr_in = len_top;
         PTR_ZERO: ptr_in = '0;
         PTR_DEC:  ptr_in = ptr_ff - 1'b1;
         PTR_INC:  ptr_in = ptr_ff + 1'b1;
         default:  ptr_in = ptr_ff;
      endcase
      case (cmd.len_op)
         LEN_CLEAR:  len_in = '0;
         LEN_INC:    len_in = len_ff + 1'b1;
         LEN_TO_PTR: len_in = ptr_ff;
         default:    len_in = len_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
      ptr_ff <= ptr_in;
   end

   // Line memory: one write port at the line end, one registered read at the pointer
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         line_mem[len_ff] <= c_ff;
      end
      if (cmd.rd_en) begin
         rd_ff <= line_mem[ptr_ff];
      end
   end

   // Decode the character that starts at the pointer; rd_ff is its lead byte
   assign nbytes = len_ff - ptr_ff;

   always_comb begin
      cp = 16'hfffd;
      if (rd_ff[7:5] == 3'b110 && nbytes >= LEN_W'(2) && is_cont(win1_ff)) begin
         cp = {5'b0, rd_ff[4:0], win1_ff[5:0]};
      end else if (rd_ff[7:4] == 4'b1110 && nbytes >= LEN_W'(3) &&
                   is_cont(win1_ff) && is_cont(win2_ff)) begin
         cp = {rd_ff[3:0], win1_ff[5:0], win2_ff[5:0]};
      end
   end

   // Shift the scan window and latch the display width
   always_ff @(posedge clock) begin
      if (cmd.scan_chk) begin
         win1_ff <= rd_ff;
         win2_ff <= win1_ff;
         wide_ff <= cp_is_wide(cp);
      end
   end

   // Pick the outgoing byte
   always_comb begin
      case (cmd.out_src)
         SRC_CARET: out_sel = CH_CARET;
         SRC_C:     out_sel = CH_UPPER_C;
         SRC_LF:    out_sel = CH_LF;
         SRC_NUL:   out_sel = CH_NUL;
         SRC_CHAR:  out_sel = c_ff;
         SRC_MEM:   out_sel = rd_ff;
         SRC_ERASE: out_sel = erase_key_ff;
         SRC_SPACE: out_sel = CH_SPACE;
         default:   out_sel = CH_NUL;
      endcase
   end

   // Result register: load a new item, drop it once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         dest_ff <= cmd.out_dest;
         byte_ff <= out_sel;
         last_ff <= cmd.out_last;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_dest     = dest_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

   // Report status to the controller
   always_comb begin
      status.canon      = canon_ff;
      status.echo       = echo_ff;
      status.nofg       = nofg_ff;
      status.is_intr    = sig_ff && (c_ff == CH_INTR);
      status.is_erase   = (c_ff == erase_key_ff) || (c_ff == CH_DEL);
      status.is_enter   = (c_ff == enter_key_ff) || (c_ff == CH_LF);
      status.is_store   = (c_ff != CH_NUL) && (len_ff < LEN_W'(LINE_CAPACITY - 1));
      status.len_zero   = (len_ff == '0);
      status.scan_more  = (ptr_ff != '0) && is_cont(rd_ff);
      status.wide       = wide_ff;
      status.drain_more = (ptr_ff != len_top);
      status.slot_free  = !valid_ff || rsp_ready;
   end

endmodule

// ===== rtl/tld_controller.sv =====
// Controller: sequences decode, erase scan, line drain and result emission.
module tld_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tld_pkg::status_type status,
   output tld_pkg::cmd_type    cmd
);
   import tld_pkg::*;

   typedef enum logic [17:0] {
      ST_IDLE       = 18'h00001,
      ST_DECODE     = 18'h00002,
      ST_INT_CARET  = 18'h00004,
      ST_INT_C      = 18'h00008,
      ST_INT_LF     = 18'h00010,
      ST_INT_NUL    = 18'h00020,
      ST_RAW_RD     = 18'h00040,
      ST_RAW_ECHO   = 18'h00080,
      ST_STORE_ECHO = 18'h00100,
      ST_ER_RD      = 18'h00200,
      ST_ER_CHK     = 18'h00400,
      ST_ER_BS1     = 18'h00800,
      ST_ER_SP      = 18'h01000,
      ST_ER_BS2     = 18'h02000,
      ST_EN_RD      = 18'h04000,
      ST_EN_DATA    = 18'h08000,
      ST_EN_NUL     = 18'h10000,
      ST_EN_LF      = 18'h20000
   } state_type;

   state_type state_ff, state_in;
   logic      col2_ff, col2_in;
   logic      int_nul;

   assign req_ready = (state_ff == ST_IDLE);
   assign int_nul   = status.canon && status.nofg;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      col2_in      = col2_ff;
      cmd          = '0;
      cmd.ptr_op   = PTR_HOLD;
      cmd.len_op   = LEN_HOLD;
      cmd.out_src  = SRC_NUL;
      cmd.out_dest = DEST_READER;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_intr) begin
               cmd.len_op = LEN_CLEAR;
               if (status.echo) begin
                  state_in = ST_INT_CARET;
               end else if (int_nul) begin
                  state_in = ST_INT_NUL;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (!status.canon) begin
               state_in = ST_RAW_RD;
            end else if (status.is_erase) begin
               if (status.len_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.ptr_op = PTR_TOP;
                  state_in   = ST_ER_RD;
               end
            end else if (status.is_enter) begin
               if (status.len_zero) begin
                  state_in = ST_EN_NUL;
               end else begin
                  cmd.ptr_op = PTR_ZERO;
                  state_in   = ST_EN_RD;
               end
            end else if (status.is_store) begin
               cmd.wr_en  = 1'b1;
               cmd.len_op = LEN_INC;
               state_in   = status.echo ? ST_STORE_ECHO : ST_IDLE;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_INT_CARET: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_CARET;
               cmd.out_dest = DEST_ECHO;
               state_in     = ST_INT_C;
            end
         end
         ST_INT_C: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_C;
               cmd.out_dest = DEST_ECHO;
               state_in     = ST_INT_LF;
            end
         end
         ST_INT_LF: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_LF;
               cmd.out_dest = DEST_ECHO;
               cmd.out_last = !int_nul;
               state_in     = int_nul ? ST_INT_NUL : ST_IDLE;
            end
         end
         ST_INT_NUL: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_NUL;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RAW_RD: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_CHAR;
               cmd.out_last = !status.echo;
               state_in     = status.echo ? ST_RAW_ECHO : ST_IDLE;
            end
         end
         ST_RAW_ECHO, ST_STORE_ECHO: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_CHAR;
               cmd.out_dest = DEST_ECHO;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         // Walk back over continuation bytes to the lead byte
         ST_ER_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_ER_CHK;
         end
         ST_ER_CHK: begin
            cmd.scan_chk = 1'b1;
            if (status.scan_more) begin
               cmd.ptr_op = PTR_DEC;
               state_in   = ST_ER_RD;
            end else begin
               cmd.len_op = LEN_TO_PTR;
               col2_in    = 1'b0;
               state_in   = status.echo ? ST_ER_BS1 : ST_IDLE;
            end
         end
         ST_ER_BS1: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_ERASE;
               cmd.out_dest = DEST_ECHO;
               state_in     = ST_ER_SP;
            end
         end
         ST_ER_SP: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_SPACE;
               cmd.out_dest = DEST_ECHO;
               state_in     = ST_ER_BS2;
            end
         end
         ST_ER_BS2: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_ERASE;
               cmd.out_dest = DEST_ECHO;
               if (status.wide && !col2_ff) begin
                  col2_in  = 1'b1;
                  state_in = ST_ER_BS1;
               end else begin
                  cmd.out_last = 1'b1;
                  state_in     = ST_IDLE;
               end
            end
         end
         // Drain the line to the reader
         ST_EN_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_EN_DATA;
         end
         ST_EN_DATA: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_MEM;
               if (status.drain_more) begin
                  cmd.ptr_op = PTR_INC;
                  state_in   = ST_EN_RD;
               end else begin
                  state_in = ST_EN_NUL;
               end
            end
         end
         ST_EN_NUL: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_NUL;
               cmd.out_last = !status.echo;
               cmd.len_op   = LEN_CLEAR;
               state_in     = status.echo ? ST_EN_LF : ST_IDLE;
            end
         end
         ST_EN_LF: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_src  = SRC_LF;
               cmd.out_dest = DEST_ECHO;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col2_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col2_ff  <= col2_in;
      end
   end

endmodule

// ===== rtl/tld_checker.sv =====
// Port-level checks for the terminal line discipline, bound to the top level.
module tld_port_checks (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_dest,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_last
);

   // Result register is empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) &&
                                  $stable(rsp_dest) && $stable(rsp_last))
      else $error("stalled result changed");

   // An accepted item keeps the block busy for at least the decode cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after accept");

   // More results pending: no new item may enter
   a_no_accept_mid_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !req_ready)
      else $error("input ready while results of an item are pending");

endmodule

bind tty_line_discipline tld_port_checks u_chk (.*);

// ===== bench/tld_checker.sv =====
// Checker for the terminal line discipline: tracks the line, predicts output bytes, compares.
module tld_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [7:0]                     req_in_byte,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_dest,
   input  logic [7:0]                     rsp_out_byte,
   input  logic                           rsp_last,
   input  logic                           csr_we,
   input  logic [tld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tld_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             fail_count,
   output int                             outstanding,
   output int                             bytes_checked
);
   import tld_pkg::*;

   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       last;
   } tty_byte_type;

   // Shadow copy of the line and the mode registers
   logic [7:0]  line_mem [LINE_CAPACITY];
   int unsigned line_len;
   logic        canon;
   logic        echo_on;
   logic        intr_on;
   logic        nofg;
   logic [7:0]  erase_code;
   logic [7:0]  enter_code;

   tty_byte_type key_bytes [$];
   tty_byte_type expected_bytes [$];

   initial begin
      fail_count    = 0;
      outstanding   = 0;
      bytes_checked = 0;
   end

   function automatic bit is_cont(logic [7:0] b);
      return b[7:6] == 2'b10;
   endfunction

   function automatic void add_byte(logic d, logic [7:0] b);
      tty_byte_type item;
      item.dest = d;
      item.data = b;
      item.last = 1'b0;
      key_bytes.push_back(item);
   endfunction

   // Display columns of the character that starts at line_mem[start]
   function automatic int glyph_columns(int unsigned start);
      int unsigned span;
      int unsigned cp;
      logic [7:0]  b0;
      span = line_len - start;
      b0   = line_mem[start];
      cp   = 32'hfffd;
      if (b0 < 8'h80)
         return 1;
      if (b0[7:5] == 3'b110 && span >= 2 && is_cont(line_mem[start+1])) begin
         cp = 32'({b0[4:0], line_mem[start+1][5:0]});
      end else if (b0[7:4] == 4'b1110 && span >= 3 && is_cont(line_mem[start+1]) &&
                   is_cont(line_mem[start+2])) begin
         cp = 32'({b0[3:0], line_mem[start+1][5:0], line_mem[start+2][5:0]});
      end
      // Only BMP code points from the East Asian wide blocks take two columns
      if ((cp >= 32'h3000 && cp <= 32'h303e) || (cp >= 32'h3041 && cp <= 32'h3096) ||
          (cp >= 32'h3099 && cp <= 32'h30ff) || (cp >= 32'h3400 && cp <= 32'h9fff) ||
          (cp >= 32'hff01 && cp <= 32'hff60) || (cp >= 32'hffe0 && cp <= 32'hffe6))
         return 2;
      return 1;
   endfunction

   // Work out every byte that one keystroke sends and queue them in order
   task automatic predict_keystroke(input logic [7:0] c);
      int unsigned start;
      int          cols;
      key_bytes.delete();
      if (intr_on && c == CH_INTR) begin
         line_len = 0;
         if (echo_on) begin
            add_byte(DEST_ECHO, CH_CARET);
            add_byte(DEST_ECHO, CH_UPPER_C);
            add_byte(DEST_ECHO, CH_LF);
         end
         if (canon && nofg)
            add_byte(DEST_READER, CH_NUL);
      end else if (!canon) begin
         add_byte(DEST_READER, c);
         if (echo_on)
            add_byte(DEST_ECHO, c);
      end else if (c == erase_code || c == CH_DEL) begin
         if (line_len > 0) begin
            start = line_len - 1;
            while (start > 0 && is_cont(line_mem[start]))
               start--;
            cols     = glyph_columns(start);
            line_len = start;
            if (echo_on) begin
               for (int k = 0; k < cols; k++) begin
                  add_byte(DEST_ECHO, erase_code);
                  add_byte(DEST_ECHO, CH_SPACE);
                  add_byte(DEST_ECHO, erase_code);
               end
            end
         end
      end else if (c == enter_code || c == CH_LF) begin
         for (int unsigned i = 0; i < line_len; i++)
            add_byte(DEST_READER, line_mem[i]);
         add_byte(DEST_READER, CH_NUL);
         line_len = 0;
         if (echo_on)
            add_byte(DEST_ECHO, CH_LF);
      end else if (c != CH_NUL) begin
         // drop silently once the line is full
         if (line_len < LINE_CAPACITY - 1) begin
            line_mem[line_len] = c;
            line_len++;
            if (echo_on)
               add_byte(DEST_ECHO, c);
         end
      end
      if (key_bytes.size() > 0)
         key_bytes[key_bytes.size()-1].last = 1'b1;
      foreach (key_bytes[i])
         expected_bytes.push_back(key_bytes[i]);
   endtask

   // Follow register writes, accepted keystrokes and delivered bytes
   always @(posedge clock) begin
      tty_byte_type want;
      if (reset) begin
         canon      = 1'b1;
         echo_on    = 1'b1;
         intr_on    = 1'b1;
         nofg       = 1'b1;
         erase_code = ERASE_KEY_RST;
         enter_code = ENTER_KEY_RST;
         line_len   = 0;
         expected_bytes.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_CANONICAL_MODE: canon      = csr_wdata[0];
               CSR_ECHO_ENABLE:    echo_on    = csr_wdata[0];
               CSR_SIGNAL_ENABLE:  intr_on    = csr_wdata[0];
               CSR_NO_FOREGROUND:  nofg       = csr_wdata[0];
               CSR_ERASE_KEY:      erase_code = csr_wdata;
               CSR_ENTER_KEY:      enter_code = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            predict_keystroke(req_in_byte);
         if (rsp_valid && rsp_ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
               $error("unexpected output byte: dest %0d byte %02h last %0d",
                      rsp_dest, rsp_out_byte, rsp_last);
               fail_count++;
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_dest !== want.dest) begin
                  $error("dest mismatch: expected %0d, got %0d", want.dest, rsp_dest);
                  fail_count++;
               end
               if (rsp_out_byte !== want.data) begin
                  $error("out_byte mismatch: expected %02h, got %02h",
                         want.data, rsp_out_byte);
                  fail_count++;
               end
               if (rsp_last !== want.last) begin
                  $error("last mismatch: expected %0d, got %0d", want.last, rsp_last);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_bytes.size();
   end

endmodule

// ===== bench/tb_tty_line_discipline.sv =====
// Testbench top for the terminal line discipline: clock, reset, keystroke stimulus and verdict.
module tb_tty_line_discipline;
   import tld_pkg::*;

   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 52;
   localparam int SETTLE_CYCLES   = 100;
   localparam int HOLD_CYCLES     = 300;
   localparam int LIMIT_CYCLES    = 4000000;

   // Register settings per phase, extremes of every register among them
   localparam bit         CANON_SET  [PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1};
   localparam bit         ECHO_SET   [PHASES] = '{1, 0, 1, 1, 1, 1, 0, 1};
   localparam bit         SIGNAL_SET [PHASES] = '{1, 1, 0, 1, 1, 0, 1, 1};
   localparam bit         NOFG_SET   [PHASES] = '{0, 1, 1, 0, 1, 0, 1, 1};
   localparam logic [7:0] ERASE_SET  [PHASES] = '{ERASE_KEY_RST, 8'h00, 8'hff, CH_DEL,
                                                  CH_INTR, 8'h41, ENTER_KEY_RST, CH_SPACE};
   localparam logic [7:0] ENTER_SET  [PHASES] = '{ENTER_KEY_RST, 8'h00, 8'hff, CH_LF,
                                                  ENTER_KEY_RST, 8'h5a, ENTER_KEY_RST, 8'hc3};

   // Code points on both sides of every wide block edge
   localparam logic [15:0] WIDE_EDGES [24] = '{
      16'h2fff, 16'h3000, 16'h303e, 16'h303f, 16'h3040, 16'h3041, 16'h3096, 16'h3097,
      16'h3098, 16'h3099, 16'h30ff, 16'h3100, 16'h33ff, 16'h3400, 16'h9fff, 16'ha000,
      16'hff00, 16'hff01, 16'hff60, 16'hff61, 16'hffdf, 16'hffe0, 16'hffe6, 16'hffe7};

   // Opening keystrokes under reset settings: wide and narrow erase, NUL,
   // erase on an empty line, interrupt with text pending, both line terminators
   localparam logic [7:0] OPENING_KEYS [21] = '{
      8'h61, 8'he4, 8'hb8, 8'h80, CH_DEL, CH_NUL, 8'hff, 8'h80, 8'hc3, 8'ha9,
      ERASE_KEY_RST, 8'hef, 8'hbc, 8'h81, ERASE_KEY_RST, ENTER_KEY_RST, CH_DEL,
      8'h62, CH_INTR, 8'h63, CH_LF};

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [7:0]            req_in_byte;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_dest;
   logic [7:0]            rsp_out_byte;
   logic                  rsp_last;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int  fail_count;
   int  outstanding;
   int  bytes_checked;
   int  keys_sent;
   int  cycle_count;
   bit  idle_on;
   bit  hold_results;
   bit  cfg_canon;
   logic [7:0] cfg_erase;
   logic [7:0] cfg_enter;

   tty_line_discipline uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_in_byte  (req_in_byte),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_dest     (rsp_dest),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   tld_checker check_u (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_dest      (rsp_dest),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last      (rsp_last),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .bytes_checked (bytes_checked)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Abort a hung run
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timed out after %0d cycles with %0d bytes outstanding",
                  cycle_count, outstanding);
         $display("Regression FAIL");
         $finish;
      end
   end

   // Mostly no gap, sometimes short, rarely long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Output side: random stalls, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_results) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_results = 1'b0;
            rsp_ready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else if (idle_on) begin
            stall_left = pick_gap();
            rsp_ready <= (stall_left == 0);
            if (stall_left > 0)
               stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Offer one keystroke and hold it until accepted; valid stays up for a back-to-back item
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = idle_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      // a NUL that the line editor ignores does not count as a keystroke
      if (!(cfg_canon && b == CH_NUL && b != cfg_erase && b != cfg_enter))
         keys_sent++;
   endtask

   // Send one character: ASCII, 2-, 3- or 4-byte UTF-8, or a broken sequence
   task automatic send_glyph();
      logic [10:0] cp11;
      logic [15:0] cp16;
      int          kind;
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
         send_byte(8'($urandom_range(8'h20, 8'h7e)));
      end else if (kind == 4) begin
         cp11 = 11'($urandom_range(0, 11'h7ff));
         send_byte({3'b110, cp11[10:6]});
         send_byte({2'b10, cp11[5:0]});
      end else if (kind < 7) begin
         if ($urandom_range(0, 1))
            cp16 = WIDE_EDGES[$urandom_range(0, 23)];
         else
            cp16 = 16'($urandom_range(16'h0800, 16'hffff));
         send_byte({4'b1110, cp16[15:12]});
         send_byte({2'b10, cp16[11:6]});
         send_byte({2'b10, cp16[5:0]});
      end else if (kind == 7) begin
         send_byte(8'($urandom_range(8'hf0, 8'hf4)));
         repeat (3) send_byte({2'b10, 6'($urandom)});
      end else if (kind == 8) begin
         // lead byte cut short by a new character
         send_byte(8'($urandom_range(8'hc0, 8'hef)));
         if ($urandom_range(0, 1))
            send_byte({2'b10, 6'($urandom)});
      end else begin
         send_byte(8'($urandom_range(8'h80, 8'hff)));
      end
   endtask

   task automatic send_erase();
      send_byte($urandom_range(0, 1) ? cfg_erase : CH_DEL);
   endtask

   task automatic send_enter();
      send_byte($urandom_range(0, 1) ? cfg_enter : CH_LF);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_setting(input bit canon, input bit echo_on, input bit intr_on,
                                input bit nofg, input logic [7:0] erase_code,
                                input logic [7:0] enter_code);
      write_reg(CSR_CANONICAL_MODE, {7'd0, canon});
      write_reg(CSR_ECHO_ENABLE, {7'd0, echo_on});
      write_reg(CSR_SIGNAL_ENABLE, {7'd0, intr_on});
      write_reg(CSR_NO_FOREGROUND, {7'd0, nofg});
      write_reg(CSR_ERASE_KEY, erase_code);
      write_reg(CSR_ENTER_KEY, enter_code);
      cfg_canon = canon;
      cfg_erase = erase_code;
      cfg_enter = enter_code;
   endtask

   // Drop valid, drain every expected byte, then let any silent work finish
   task automatic settle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int phase_base;
      int r;
      int n;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_in_byte  = 8'h00;
      csr_we       = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      keys_sent    = 0;
      idle_on      = 1'b1;
      hold_results = 1'b0;
      cfg_canon    = 1'b1;
      cfg_erase    = ERASE_KEY_RST;
      cfg_enter    = ENTER_KEY_RST;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed line editing under reset settings
      foreach (OPENING_KEYS[i])
         send_byte(OPENING_KEYS[i]);

      // Directed raw mode: NUL passes through, interrupt is still taken as a signal
      settle();
      apply_setting(1'b0, 1'b1, 1'b1, 1'b1, ERASE_KEY_RST, ENTER_KEY_RST);
      send_byte(CH_NUL);
      send_byte(CH_INTR);
      send_byte(8'h7e);

      // Random phases, one register setting each
      for (int p = 0; p < PHASES; p++) begin
         settle();
         apply_setting(CANON_SET[p], ECHO_SET[p], SIGNAL_SET[p], NOFG_SET[p],
                       ERASE_SET[p], ENTER_SET[p]);
         idle_on    = (p != 1 && p != 4);
         phase_base = keys_sent;
         if (p == 2)
            hold_results = 1'b1;
         while (keys_sent - phase_base < ITEMS_PER_PHASE) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               // short line, maybe edited, then released
               n = $urandom_range(1, 8);
               repeat (n) send_glyph();
               if ($urandom_range(0, 4) < 2)
                  repeat ($urandom_range(1, 3)) send_erase();
               send_enter();
            end else if (r < 55) begin
               // long line that can run into the full buffer
               n = $urandom_range(28, 36);
               repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7e)));
               repeat ($urandom_range(0, 2)) send_erase();
               send_enter();
            end else if (r < 65) begin
               repeat ($urandom_range(0, 4)) send_glyph();
               send_byte(CH_INTR);
            end else if (r < 72) begin
               // erase past the start of the line
               repeat ($urandom_range(1, 3)) send_glyph();
               repeat (4) send_erase();
            end else begin
               send_byte(8'($urandom_range(0, 255)));
            end
         end
      end

      settle();
      $display("Sent %0d keystrokes over %0d register settings; checked %0d output bytes.",
               keys_sent, PHASES + 2, bytes_checked);
      $display("Covered UTF-8 erase widths, interrupts, full lines, raw mode and stalls.");
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
